### design/u8vc_pkg.sv
// Shared types, constants and helpers for the UTF-8 validate-and-count block.
package u8vc_pkg;

  // Width of the internal character counter (range 8 to 64)
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned OUT_WIDTH   = 32;

  // Lead-pattern masks and match values
  localparam logic [7:0] MASK_ASCII = 8'h80;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_ASCII  = 8'h00;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [1:0]             pend_t;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_cls_e;

  // One finished string as handed from the tracker to the output register
  typedef struct packed {
    logic [OUT_WIDTH-1:0] char_count;
    logic                 valid_res;
  } result_t;

  // Counter value as shown on the 32-bit result port
  function automatic logic [OUT_WIDTH-1:0] count_to_out(input count_t c);
    logic [63:0] wide;
    wide = 64'(c);
    return wide[OUT_WIDTH-1:0];
  endfunction

endpackage

### design/u8vc_classify.sv
// Byte classifier: decodes the UTF-8 lead pattern of one byte.
module u8vc_classify
  import u8vc_pkg::*;
(
  input  logic [7:0] data_byte_i,
  output byte_cls_e  cls_o
);

  // Priority decode on the high bits, longest prefix last
  always_comb begin
    if ((data_byte_i & MASK_ASCII) == PAT_ASCII) begin
      cls_o = CLS_ASCII;
    end else if ((data_byte_i & MASK_CONT) == PAT_CONT) begin
      cls_o = CLS_CONT;
    end else if ((data_byte_i & MASK_LEAD2) == PAT_LEAD2) begin
      cls_o = CLS_LEAD2;
    end else if ((data_byte_i & MASK_LEAD3) == PAT_LEAD3) begin
      cls_o = CLS_LEAD3;
    end else if ((data_byte_i & MASK_LEAD4) == PAT_LEAD4) begin
      cls_o = CLS_LEAD4;
    end else begin
      cls_o = CLS_BAD;
    end
  end

endmodule

### design/u8vc_track.sv
// Sequence tracker: owed continuations, validity and the character count.
module u8vc_track
  import u8vc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  byte_cls_e cls_i,
  input  logic      last_i,
  output result_t   res_o
);

  pend_t  pend_q,  pend_d;
  logic   ok_q,    ok_d;
  count_t cnt_q,   cnt_d;

  pend_t  pend_n;
  logic   ok_n;
  count_t cnt_n;
  logic   bump;

  // Next state for one word
  always_comb begin
    pend_n = pend_q;
    ok_n   = ok_q;
    bump   = 1'b0;
    if (pend_q != 2'd0 && cls_i == CLS_CONT) begin
      pend_n = pend_q - 2'd1;
      bump   = (pend_q == 2'd1);
    end else begin
      // a pending sequence broken by a non-continuation is dropped
      if (pend_q != 2'd0) begin
        ok_n = 1'b0;
      end
      pend_n = 2'd0;
      case (cls_i)
        CLS_ASCII: bump   = 1'b1;
        CLS_LEAD2: pend_n = 2'd1;
        CLS_LEAD3: pend_n = 2'd2;
        CLS_LEAD4: pend_n = 2'd3;
        CLS_CONT:  ok_n   = 1'b0;
        default:   ok_n   = 1'b0;
      endcase
    end
    // saturating count
    cnt_n = (bump && cnt_q != '1) ? cnt_q + count_t'(1) : cnt_q;
  end

  // Result of a final word; a string cut short is not valid
  always_comb begin
    res_o.char_count = count_to_out(cnt_n);
    res_o.valid_res  = ok_n && (pend_n == 2'd0);
  end

  // State update, back to reset values after the final word
  always_comb begin
    pend_d = pend_q;
    ok_d   = ok_q;
    cnt_d  = cnt_q;
    if (step_i) begin
      if (last_i) begin
        pend_d = 2'd0;
        ok_d   = 1'b1;
        cnt_d  = '0;
      end else begin
        pend_d = pend_n;
        ok_d   = ok_n;
        cnt_d  = cnt_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      ok_q   <= 1'b1;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      ok_q   <= ok_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

### design/utf8_validate_and_count.sv
// Top level: UTF-8 validator and character counter with input and result registers.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------
//   in      | input     | in_valid_i/in_stall_o  | data_byte_i, last_i
//   out     | output    | out_valid_o/out_stall_i| char_count_o, valid_res_o
//
// One word per cycle is taken while in_stall_o is low. A word is held in the
// input register, then updates the tracker; a final word moves into the result
// register once that is free and shows its result there. Reset (rst_ni low) empties
// both registers and returns the tracker to zero count, nothing owed, valid.
// While a result waits under out_stall_i, non-final words keep flowing; a
// final word waits in the input register, and in_stall_o is then raised.
module utf8_validate_and_count
  import u8vc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_WIDTH-1:0] char_count_o,
  output logic                 valid_res_o
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q,   byte_d;
  logic       last_q,   last_d;
  logic       out_vld_q, out_vld_d;
  result_t    res_q,    res_d;

  byte_cls_e  cls;
  result_t    res;
  logic       out_free;
  logic       adv;
  logic       in_take;

  // Handshake: a final word moves on only into a free result register
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && (!last_q || out_free);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  u8vc_classify u_classify (
    .data_byte_i (byte_q),
    .cls_o       (cls)
  );

  u8vc_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .cls_i  (cls),
    .last_i (last_q),
    .res_o  (res)
  );

  // Input register
  always_comb begin
    in_vld_d = in_vld_q;
    byte_d   = byte_q;
    last_d   = last_q;
    if (in_take) begin
      in_vld_d = 1'b1;
      byte_d   = data_byte_i;
      last_d   = last_i;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  // Result register
  always_comb begin
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (adv && last_q) begin
      out_vld_d = 1'b1;
      res_d     = res;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    res_q  <= res_d;
  end

  assign out_valid_o  = out_vld_q;
  assign char_count_o = res_q.char_count;
  assign valid_res_o  = res_q.valid_res;

endmodule

### design/u8vc_checker.sv
// Port-level checks for the UTF-8 validate-and-count block, with bind.
module u8vc_checker
  import u8vc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [7:0]           data_byte_i,
  input logic                 last_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [OUT_WIDTH-1:0] char_count_o,
  input logic                 valid_res_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_count_o)
      && $stable(valid_res_o))
    else $error("result word changed while stalled");

  // Input is held back only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with result side free");

  // A final word taken is loaded into the result register once that register is free
  a_last_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) ##1 (!out_valid_o || !out_stall_i)
      |=> out_valid_o)
    else $error("final word did not produce a result");

  // Every string has at least one byte, so a valid one has a character
  a_valid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> char_count_o != '0)
    else $error("valid string reported with zero characters");

endmodule

bind utf8_validate_and_count u8vc_checker u_u8vc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .data_byte_i  (data_byte_i),
  .last_i       (last_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .char_count_o (char_count_o),
  .valid_res_o  (valid_res_o)
);

### test/tb_utf8_validate_and_count.sv
// Self-checking testbench for the UTF-8 validate-and-count block.
module tb_utf8_validate_and_count;
  import u8vc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i  = 8'h00;
  logic                 last_i       = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [OUT_WIDTH-1:0] char_count_o;
  logic                 valid_res_o;

  // Words waiting to be sent, and string results still owed by the block
  in_word_t byte_q[$];
  result_t  tally_q[$];

  // Idle percentages for the current phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int errors      = 0;
  int n_strings   = 0;
  int n_words     = 0;
  int n_checked   = 0;
  int n_malformed = 0;

  // Predicted tracker state
  pend_t  owed;
  logic   well_formed;
  count_t chars_seen;

  in_word_t nxt;
  result_t  want;

  utf8_validate_and_count i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_count_o (char_count_o),
    .valid_res_o  (valid_res_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic byte_cls_e lead_kind(input logic [7:0] b);
    if ((b & MASK_ASCII) == PAT_ASCII) return CLS_ASCII;
    if ((b & MASK_CONT) == PAT_CONT) return CLS_CONT;
    if ((b & MASK_LEAD2) == PAT_LEAD2) return CLS_LEAD2;
    if ((b & MASK_LEAD3) == PAT_LEAD3) return CLS_LEAD3;
    if ((b & MASK_LEAD4) == PAT_LEAD4) return CLS_LEAD4;
    return CLS_BAD;
  endfunction

  function void reset_tracker();
    owed        = '0;
    well_formed = 1'b1;
    chars_seen  = '0;
  endfunction

  // Counter sticks at all ones
  function void count_char();
    if (chars_seen != '1) chars_seen = chars_seen + 1'b1;
  endfunction

  // Nothing is owed when a new character begins
  function void open_char(input byte_cls_e k);
    case (k)
      CLS_ASCII: count_char();
      CLS_LEAD2: owed = 2'd1;
      CLS_LEAD3: owed = 2'd2;
      CLS_LEAD4: owed = 2'd3;
      default:   well_formed = 1'b0;
    endcase
  endfunction

  // Feed one accepted word; a final word queues the string's result
  function void track_word(input logic [7:0] b, input logic fin);
    byte_cls_e k;
    result_t   r;
    k = lead_kind(b);
    if (owed != '0) begin
      if (k == CLS_CONT) begin
        owed = owed - 1'b1;
        if (owed == '0) count_char();
      end else begin
        // broken sequence: drop the partial char, rescan this byte
        well_formed = 1'b0;
        owed        = '0;
        open_char(k);
      end
    end else begin
      open_char(k);
    end
    if (fin) begin
      if (owed != '0) well_formed = 1'b0;
      r.char_count = OUT_WIDTH'(chars_seen);
      r.valid_res  = well_formed;
      tally_q.push_back(r);
      reset_tracker();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function void send_string(input logic [7:0] s[$]);
    in_word_t w;
    foreach (s[i]) begin
      w.data = s[i];
      w.last = (i == s.size() - 1);
      byte_q.push_back(w);
    end
    n_strings++;
    n_words += s.size();
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Appends one well-formed character of random length and content
  function automatic void add_char(ref logic [7:0] s[$]);
    case ($urandom_range(3))
      0: s.push_back({1'b0, 7'($urandom)});
      1: begin
        s.push_back({3'b110, 5'($urandom)});
        s.push_back(cont_byte());
      end
      2: begin
        s.push_back({4'b1110, 4'($urandom)});
        repeat (2) s.push_back(cont_byte());
      end
      default: begin
        s.push_back({5'b11110, 3'($urandom)});
        repeat (3) s.push_back(cont_byte());
      end
    endcase
  endfunction

  // Builds one random string and queues it; returns its length in words
  function automatic int random_string();
    logic [7:0] s[$];
    int         roll;
    int         nchar;
    int         pos;
    roll  = $urandom_range(99);
    nchar = ($urandom_range(19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    if (roll < 85) begin
      repeat (nchar) add_char(s);
      if (roll >= 70) begin
        // one random corruption of an otherwise clean string
        n_malformed++;
        pos = $urandom_range(s.size() - 1);
        case ($urandom_range(2))
          0: s[pos] = 8'($urandom);
          1: s.insert(pos, cont_byte());
          default: if (s.size() > 1) void'(s.pop_back());
        endcase
      end
    end else begin
      n_malformed++;
      repeat ($urandom_range(1, 10)) s.push_back(8'($urandom));
    end
    send_string(s);
    return s.size();
  endfunction

  // Short hand-picked strings: field extremes and every special case
  task automatic directed_strings();
    send_string('{8'h00});                                   // lone NUL
    send_string('{8'h7F, 8'h80});                            // stray continuation
    send_string('{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                  8'hF0, 8'h9F, 8'h98, 8'h80});              // 2-, 3-, 4-byte chars
    send_string('{8'hFF});                                   // invalid lead
    send_string('{8'hE2, 8'h41, 8'hF8});                     // broken seq, bad lead
    send_string('{8'hF7, 8'hBF, 8'hBF});                     // cut short at end
    send_string('{8'hC0, 8'hC0, 8'hBF});                     // broken then complete
    send_string('{8'hDF, 8'hEF});                            // broken, then cut short
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one word held until accepted, then the next or an idle cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) track_word(data_byte_i, last_i);
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_q.pop_front();
        in_valid_i  <= 1'b1;
        data_byte_i <= nxt.data;
        last_i      <= nxt.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (tally_q.size() == 0) begin
          $error("result with no string pending: char_count %0d valid_res %0b",
                 char_count_o, valid_res_o);
          errors++;
        end else begin
          want = tally_q.pop_front();
          n_checked++;
          if (char_count_o !== want.char_count) begin
            $error("char_count: expected %0d, got %0d", want.char_count, char_count_o);
            errors++;
          end
          if (valid_res_o !== want.valid_res) begin
            $error("valid_res: expected %0b, got %0b", want.valid_res, valid_res_o);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: reset, directed strings, then four idling phases
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    reset_tracker();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_strings();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      sent = 0;
      while (sent < 280) sent += random_string();
      while (byte_q.size() != 0) @(posedge clk_i);
    end

    // drain: last word accepted, every result back, then a quiet spell unstalled
    while (in_valid_i) @(posedge clk_i);
    while (tally_q.size() != 0) @(posedge clk_i);
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);

    $display("Sent %0d strings in %0d words (%0d malformed), checked %0d results,",
             n_strings, n_words, n_malformed, n_checked);
    $display("across unthrottled, sender-idle, receiver-stall and light-mixed phases.");
    if (errors == 0) begin
      $display("[utf8_validate_and_count] OK");
    end else begin
      $display("[utf8_validate_and_count] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Timed out with %0d words and %0d results outstanding",
             byte_q.size(), tally_q.size());
    $display("[utf8_validate_and_count] ERROR");
    $finish;
  end

endmodule

### filelist.f
design/u8vc_pkg.sv
design/u8vc_classify.sv
design/u8vc_track.sv
design/utf8_validate_and_count.sv
design/u8vc_checker.sv
test/tb_utf8_validate_and_count.sv
